// ----- hw/rtl/huber_robust_kernel_core_assert.svh -----
// Assertion macros for the Huber kernel core checker.
`ifndef HUBER_ROBUST_KERNEL_CORE_ASSERT_SVH
`define HUBER_ROBUST_KERNEL_CORE_ASSERT_SVH

// Same-cycle implication, disabled while dis is high.
`define HRK_ASSERT_NOW(name, clk, dis, ant, con) \
  name: assert property (@(posedge clk) disable iff (dis) (ant) |-> (con)) \
    else $error("hrk check failed");

// Next-cycle implication, disabled while dis is high.
`define HRK_ASSERT_NEXT(name, clk, dis, ant, con) \
  name: assert property (@(posedge clk) disable iff (dis) (ant) |=> (con)) \
    else $error("hrk check failed");

`endif

// ----- hw/rtl/hrk_pkg.sv -----
// Shared widths and constants of the Huber kernel core.
`default_nettype none
package hrk_pkg;
  localparam int unsigned ErrW   = 32;
  localparam int unsigned ThrW   = 24;
  localparam int unsigned LossW  = 32;
  localparam int unsigned D1W    = 17;
  localparam int unsigned D2W    = 32;
  localparam logic [ThrW-1:0] ThrReset = 24'h010000;
  localparam logic [D1W-1:0]  D1Max    = 17'h1FFFF;
  localparam logic [D2W:0]    D2Sat    = 33'h080000000;
endpackage
`default_nettype wire

// ----- hw/rtl/hrk_sqrt_cell.sv -----
// One digit-pair step of the integer square root chain.
`default_nettype none
module hrk_sqrt_cell #(
  parameter int unsigned SW   = 24,
  parameter int unsigned SDW  = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              vld_i,
  input  wire logic [2*SW-1:0]   rad_i,
  input  wire logic [SW+1:0]     rem_i,
  input  wire logic [SW-1:0]     root_i,
  input  wire logic [SDW-1:0]    side_i,
  output logic                   vld_o,
  output logic [2*SW-1:0]        rad_o,
  output logic [SW+1:0]          rem_o,
  output logic [SW-1:0]          root_o,
  output logic [SDW-1:0]         side_o
);
  logic [SW+1:0] cur, trial;
  logic          ge;

  assign cur   = {rem_i[SW-1:0], rad_i[2*SW-1 -: 2]};
  assign trial = {root_i, 2'b01};
  assign ge    = cur >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_o  <= rad_i << 2;
      rem_o  <= ge ? cur - trial : cur;
      root_o <= {root_i[SW-2:0], ge};
      side_o <= side_i;
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/hrk_div_cell.sv -----
// One restoring-division step: one quotient bit per cell.
`default_nettype none
module hrk_div_cell #(
  parameter int unsigned NW  = 17,
  parameter int unsigned DW  = 24,
  parameter int unsigned SDW = 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            vld_i,
  input  wire logic [NW-1:0]   num_i,
  input  wire logic [DW-1:0]   rem_i,
  input  wire logic [DW-1:0]   den_i,
  input  wire logic [NW-1:0]   quo_i,
  input  wire logic [SDW-1:0]  side_i,
  output logic                 vld_o,
  output logic [NW-1:0]        num_o,
  output logic [DW-1:0]        rem_o,
  output logic [DW-1:0]        den_o,
  output logic [NW-1:0]        quo_o,
  output logic [SDW-1:0]       side_o
);
  logic [DW:0] cur, diff;
  logic        ge;

  assign cur  = {rem_i, num_i[NW-1]};
  assign diff = cur - {1'b0, den_i};
  assign ge   = cur >= {1'b0, den_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_o  <= num_i << 1;
      rem_o  <= ge ? diff[DW-1:0] : cur[DW-1:0];
      den_o  <= den_i;
      quo_o  <= {quo_i[NW-2:0], ge};
      side_o <= side_i;
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/huber_robust_kernel_core.sv -----
// Top level of the Huber robust kernel: sqrt chain and two divider chains.
// Channel   Signals                                      Direction
// input     in_valid_i / in_ready_o, sq_error_i          in
// output    out_valid_o / out_ready_i, loss_value_o,     out
//           first_deriv_o, second_deriv_o
// config    threshold_we_i, threshold_i                  in
// One item per cycle while the output is not stalled; the chain holds one cell per
// root bit and per quotient bit of both divides.
// Reset clears all valid bits and loads threshold 1.0.
// A stalled output freezes the whole cell chain; in_ready_o follows that.
`default_nettype none
module huber_robust_kernel_core #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        threshold_we_i,
  input  wire logic [hrk_pkg::ThrW-1:0]    threshold_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [hrk_pkg::ErrW-1:0]    sq_error_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [hrk_pkg::LossW-1:0]        loss_value_o,
  output logic [hrk_pkg::D1W-1:0]          first_deriv_o,
  output logic [hrk_pkg::D2W-1:0]          second_deriv_o
);
  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned EW  = hrk_pkg::ErrW;
  localparam int unsigned TW  = hrk_pkg::ThrW;
  localparam int unsigned LW0 = hrk_pkg::LossW;
  localparam int unsigned VW  = EW + F;
  localparam int unsigned SW  = (VW + 1) / 2;
  localparam int unsigned DQW = 2 * TW;
  localparam int unsigned CW  = (VW > DQW) ? VW : DQW;
  localparam int unsigned PW  = TW + SW;
  localparam int unsigned LW  = (PW + 1 > DQW) ? PW + 1 : DQW;
  localparam int unsigned Q1W = F + 1;
  localparam int unsigned N2W = 2 * F + 1;
  localparam int unsigned D2W = EW + 1;
  localparam int unsigned XW  = (N2W > 33) ? N2W : 33;
  localparam int unsigned QXW = (Q1W > 17) ? Q1W : 17;
  localparam int unsigned S0W = 1 + DQW + TW + EW;
  localparam int unsigned S1W = 1 + LW0 + EW;
  localparam int unsigned S2W = 1 + LW0 + Q1W;
  localparam logic [hrk_pkg::D1W-1:0] D1One =
      (F >= 17) ? hrk_pkg::D1Max : 17'(1 << F);

  logic adv;
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  logic [TW-1:0] thr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= hrk_pkg::ThrReset;
    end else if (threshold_we_i) begin
      thr_q <= threshold_i;
    end
  end

  // entry stage: delta squared and inlier test
  logic [VW-1:0]  es;
  logic [DQW-1:0] dsq;
  logic           inl;
  assign es  = {sq_error_i, {F{1'b0}}};
  assign dsq = DQW'(thr_q) * DQW'(thr_q);
  assign inl = CW'(es) <= CW'(dsq);

  logic [SW:0]         sq_vld;
  logic [2*SW-1:0]     sq_rad  [SW+1];
  logic [SW+1:0]       sq_rem  [SW+1];
  logic [SW-1:0]       sq_root [SW+1];
  logic [S0W-1:0]      sq_side [SW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld[0] <= 1'b0;
    end else if (adv) begin
      sq_vld[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_rad[0]  <= (2*SW)'(es);
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      sq_side[0] <= {inl, dsq, thr_q, sq_error_i};
    end
  end

  for (genvar i = 0; i < SW; i++) begin : g_sqrt
    hrk_sqrt_cell #(.SW(SW), .SDW(S0W)) u_cell (
      .clk_i, .rst_ni, .en_i(adv),
      .vld_i(sq_vld[i]), .rad_i(sq_rad[i]), .rem_i(sq_rem[i]),
      .root_i(sq_root[i]), .side_i(sq_side[i]),
      .vld_o(sq_vld[i+1]), .rad_o(sq_rad[i+1]), .rem_o(sq_rem[i+1]),
      .root_o(sq_root[i+1]), .side_o(sq_side[i+1])
    );
  end

  // loss stage: 2*delta*s - delta^2, saturated, or the error itself for inliers
  logic [EW-1:0]  b_e;
  logic [TW-1:0]  b_d;
  logic [DQW-1:0] b_dsq;
  logic           b_inl;
  logic [PW-1:0]  prod;
  logic [LW-1:0]  diff, lsh;
  logic [LW0-1:0] loss;
  assign b_e   = sq_side[SW][EW-1:0];
  assign b_d   = sq_side[SW][EW +: TW];
  assign b_dsq = sq_side[SW][EW+TW +: DQW];
  assign b_inl = sq_side[SW][S0W-1];
  assign prod  = PW'(b_d) * PW'(sq_root[SW]);
  assign diff  = LW'({prod, 1'b0}) - LW'(b_dsq);
  assign lsh   = diff >> F;
  assign loss  = b_inl ? b_e : (|lsh[LW-1:LW0] ? '1 : lsh[LW0-1:0]);

  logic [Q1W:0]    d1_vld;
  logic [Q1W-1:0]  d1_num  [Q1W+1];
  logic [SW-1:0]   d1_rem  [Q1W+1];
  logic [SW-1:0]   d1_den  [Q1W+1];
  logic [Q1W-1:0]  d1_quo  [Q1W+1];
  logic [S1W-1:0]  d1_side [Q1W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_vld[0] <= 1'b0;
    end else if (adv) begin
      d1_vld[0] <= sq_vld[SW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d1_num[0]  <= {b_d[0], {F{1'b0}}};
      d1_rem[0]  <= SW'(b_d >> 1);
      d1_den[0]  <= sq_root[SW];
      d1_quo[0]  <= '0;
      d1_side[0] <= {b_inl, loss, b_e};
    end
  end

  for (genvar i = 0; i < Q1W; i++) begin : g_div1
    hrk_div_cell #(.NW(Q1W), .DW(SW), .SDW(S1W)) u_cell (
      .clk_i, .rst_ni, .en_i(adv),
      .vld_i(d1_vld[i]), .num_i(d1_num[i]), .rem_i(d1_rem[i]),
      .den_i(d1_den[i]), .quo_i(d1_quo[i]), .side_i(d1_side[i]),
      .vld_o(d1_vld[i+1]), .num_o(d1_num[i+1]), .rem_o(d1_rem[i+1]),
      .den_o(d1_den[i+1]), .quo_o(d1_quo[i+1]), .side_o(d1_side[i+1])
    );
  end

  logic [N2W:0]    d2_vld;
  logic [N2W-1:0]  d2_num  [N2W+1];
  logic [D2W-1:0]  d2_rem  [N2W+1];
  logic [D2W-1:0]  d2_den  [N2W+1];
  logic [N2W-1:0]  d2_quo  [N2W+1];
  logic [S2W-1:0]  d2_side [N2W+1];

  assign d2_vld[0]  = d1_vld[Q1W];
  assign d2_num[0]  = {d1_quo[Q1W], {F{1'b0}}};
  assign d2_rem[0]  = '0;
  assign d2_den[0]  = {d1_side[Q1W][EW-1:0], 1'b0};
  assign d2_quo[0]  = '0;
  assign d2_side[0] = {d1_side[Q1W][S1W-1], d1_side[Q1W][EW +: LW0], d1_quo[Q1W]};

  for (genvar i = 0; i < N2W; i++) begin : g_div2
    hrk_div_cell #(.NW(N2W), .DW(D2W), .SDW(S2W)) u_cell (
      .clk_i, .rst_ni, .en_i(adv),
      .vld_i(d2_vld[i]), .num_i(d2_num[i]), .rem_i(d2_rem[i]),
      .den_i(d2_den[i]), .quo_i(d2_quo[i]), .side_i(d2_side[i]),
      .vld_o(d2_vld[i+1]), .num_o(d2_num[i+1]), .rem_o(d2_rem[i+1]),
      .den_o(d2_den[i+1]), .quo_o(d2_quo[i+1]), .side_o(d2_side[i+1])
    );
  end

  // output stage: clamps and inlier select
  logic [Q1W-1:0]        f_q;
  logic                  f_inl;
  logic [XW-1:0]         magx;
  logic [31:0]           mag32;
  logic [QXW-1:0]        qx;
  logic [hrk_pkg::D1W-1:0] d1c;
  assign f_q   = d2_side[N2W][Q1W-1:0];
  assign f_inl = d2_side[N2W][S2W-1];
  assign magx  = XW'(d2_quo[N2W]);
  assign mag32 = (magx > XW'(hrk_pkg::D2Sat)) ? hrk_pkg::D2Sat[31:0] : magx[31:0];
  assign qx    = QXW'(f_q);
  assign d1c   = (qx > QXW'(hrk_pkg::D1Max)) ? hrk_pkg::D1Max : qx[16:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (adv) begin
      out_valid_o <= d2_vld[N2W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      loss_value_o   <= d2_side[N2W][Q1W +: LW0];
      first_deriv_o  <= f_inl ? D1One : d1c;
      second_deriv_o <= f_inl ? '0 : 32'(0) - mag32;
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/hrk_checker.sv -----
// Port-level checker for the Huber kernel core, bound to the top level.
`default_nettype none
`include "huber_robust_kernel_core_assert.svh"
module hrk_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [31:0] loss_value_o,
  input wire logic [16:0] first_deriv_o,
  input wire logic [31:0] second_deriv_o
);
  `HRK_ASSERT_NEXT(a_out_hold, clk_i, !rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(loss_value_o) && $stable(first_deriv_o) && $stable(second_deriv_o))
  `HRK_ASSERT_NOW(a_d2_sign, clk_i, !rst_ni, out_valid_o, second_deriv_o == 32'd0 || second_deriv_o[31])
  `HRK_ASSERT_NOW(a_ready_free, clk_i, !rst_ni, !out_valid_o || out_ready_i, in_ready_o)
  `HRK_ASSERT_NEXT(a_reset_idle, clk_i, 1'b0, !rst_ni, !out_valid_o)
endmodule

bind huber_robust_kernel_core hrk_checker u_hrk_checker (
  .clk_i, .rst_ni, .in_ready_o, .out_valid_o, .out_ready_i,
  .loss_value_o, .first_deriv_o, .second_deriv_o
);
`default_nettype wire

// ----- tb/huber_robust_kernel_core_test.sv -----
// Testbench for the Huber robust kernel core: predicted kernel values vs. DUT.
`timescale 1ns / 1ps
`default_nettype none
module huber_robust_kernel_core_test;
  localparam int unsigned FracBits = 16;
  localparam int unsigned Latency  = 77;

  typedef struct packed {
    logic [hrk_pkg::LossW-1:0] loss;
    logic [hrk_pkg::D1W-1:0]   d1;
    logic [hrk_pkg::D2W-1:0]   d2;
  } kernel_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic threshold_we_i = 1'b0;
  logic [hrk_pkg::ThrW-1:0] threshold_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [hrk_pkg::ErrW-1:0] sq_error_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [hrk_pkg::LossW-1:0] loss_value_o;
  logic [hrk_pkg::D1W-1:0] first_deriv_o;
  logic [hrk_pkg::D2W-1:0] second_deriv_o;

  huber_robust_kernel_core #(.FRAC_BITS(FracBits)) i_dut (
    .clk_i, .rst_ni, .threshold_we_i, .threshold_i,
    .in_valid_i, .in_ready_o, .sq_error_i,
    .out_valid_o, .out_ready_i, .loss_value_o, .first_deriv_o, .second_deriv_o
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  logic [hrk_pkg::ErrW-1:0] pending_errs[$];
  kernel_out_t expected_kernels[$];
  logic [hrk_pkg::ThrW-1:0] delta_model = hrk_pkg::ThrReset;
  int unsigned n_errors = 0;
  int unsigned n_checked = 0;
  int unsigned n_outliers = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_cycles = 0;

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic kernel_out_t huber_kernel(input logic [hrk_pkg::ErrW-1:0] e,
                                               input logic [hrk_pkg::ThrW-1:0] d);
    kernel_out_t r;
    logic [63:0] dsq, es, s, loss, q, mag;
    dsq = 64'(d) * 64'(d);
    es = 64'(e) << FracBits;
    if (es <= dsq) begin
      r.loss = e;
      r.d1 = 17'd1 << FracBits;
      r.d2 = '0;
    end else begin
      s = int_sqrt(es);
      loss = (2 * 64'(d) * s - dsq) >> FracBits;
      q = (64'(d) << FracBits) / s;
      mag = (q << FracBits) / (2 * 64'(e));
      if (loss > 64'hFFFF_FFFF) loss = 64'hFFFF_FFFF;
      if (mag > 64'(hrk_pkg::D2Sat)) mag = 64'(hrk_pkg::D2Sat);
      r.loss = loss[31:0];
      r.d1 = (q > 64'(hrk_pkg::D1Max)) ? hrk_pkg::D1Max : q[hrk_pkg::D1W-1:0];
      r.d2 = 32'(64'd0 - mag);
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %h, expected %h", what, got, want);
    n_errors++;
  endtask

  // driver
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      expected_kernels.push_back(huber_kernel(sq_error_i, delta_model));
      if ((64'(sq_error_i) << FracBits) > 64'(delta_model) * 64'(delta_model))
        n_outliers++;
    end
    if (!(in_valid_i && !in_ready_o)) begin
      if (rst_ni && pending_errs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        sq_error_i <= pending_errs.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    kernel_out_t want;
    if (out_valid_o && out_ready_i) begin
      if (expected_kernels.size() == 0) begin
        report_mismatch("unexpected transfer", 64'(loss_value_o), 64'd0);
      end else begin
        want = expected_kernels.pop_front();
        n_checked++;
        if (loss_value_o !== want.loss)
          report_mismatch("loss_value", 64'(loss_value_o), 64'(want.loss));
        if (first_deriv_o !== want.d1)
          report_mismatch("first_deriv", 64'(first_deriv_o), 64'(want.d1));
        if (second_deriv_o !== want.d2)
          report_mismatch("second_deriv", 64'(second_deriv_o), 64'(want.d2));
      end
    end
    if (hold_cycles > 0) begin
      out_ready_i <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready_i <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic drain();
    while (pending_errs.size() > 0 || in_valid_i || expected_kernels.size() > 0)
      @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
  endtask

  task automatic set_threshold(input logic [hrk_pkg::ThrW-1:0] v);
    threshold_we_i <= 1'b1;
    threshold_i <= v;
    @(posedge clk_i);
    threshold_we_i <= 1'b0;
    delta_model = v;
  endtask

  function automatic logic [hrk_pkg::ErrW-1:0] rand_err(input logic [hrk_pkg::ThrW-1:0] d);
    logic [63:0] dsq_int;
    dsq_int = (64'(d) * 64'(d)) >> FracBits;
    case ($urandom_range(4))
      0: return $urandom();
      1: return $urandom_range(255);
      2: return 32'(dsq_int) + $urandom_range(4) - 2;
      3: return $urandom() >> $urandom_range(31);
      default: return $urandom_range(32'hFFFF_FFFF, 32'hFFFF_FF00);
    endcase
  endfunction

  task automatic random_phase(input int n, input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (n) pending_errs.push_back(rand_err(delta_model));
    drain();
  endtask

  initial begin
    logic [hrk_pkg::ErrW-1:0] directed[$];
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed = '{32'h0, 32'h1, 32'h2, 32'h10000, 32'h10001, 32'hFFFFFFFF,
                 32'hFFFFFFFE, 32'h80000000, 32'h7FFFFFFF, 32'h40000, 32'hAAAAAAAA,
                 32'h55555555};
    foreach (directed[i]) pending_errs.push_back(directed[i]);
    drain();
    set_threshold(24'h0);
    foreach (directed[i]) if (i < 6) pending_errs.push_back(directed[i]);
    drain();
    set_threshold(24'hFFFFFF);
    foreach (directed[i]) if (i < 6) pending_errs.push_back(directed[i]);
    drain();
    set_threshold(24'h000001);
    random_phase(120, 15, 78);
    set_threshold(24'h020000);
    random_phase(120, 78, 15);
    set_threshold(24'($urandom_range(24'hFFFFFF)));
    random_phase(120, 0, 0);
    set_threshold(24'h008000);
    hold_cycles = 300;
    random_phase(140, 0, 0);
    $display("covered %0d results, %0d outliers, thresholds zero to max, stalls",
             n_checked, n_outliers);
    if (n_errors == 0) $display("huber_robust_kernel_core_test: done, clean");
    else $display("huber_robust_kernel_core_test: done, errors");
    $finish;
  end

  initial begin
    #4000000;
    $display("huber_robust_kernel_core_test: done, errors");
    $finish;
  end
endmodule
`default_nettype wire

// ----- huber_robust_kernel_core.f -----
+incdir+hw/rtl
hw/rtl/hrk_pkg.sv
hw/rtl/hrk_sqrt_cell.sv
hw/rtl/hrk_div_cell.sv
hw/rtl/huber_robust_kernel_core.sv
hw/rtl/hrk_checker.sv
tb/huber_robust_kernel_core_test.sv
